>>> src/ssid_pkg.sv
// shared types, constants and arithmetic helpers of the image downscaler
package ssid_pkg;

   localparam int NumCh     = 4;
   localparam int TapCount  = 4;
   localparam int WinW      = 32;
   localparam int RingW     = 48;
   localparam int CoefW     = 16;
   localparam int FracBits  = 28;

   localparam logic [7:0]        ByteMax      = 8'hFF;
   localparam logic [10:0]       OutWidthRst  = 11'd1024;
   localparam logic signed [RingW-1:0] ByteSat  = 48'sh00FF0000000;
   localparam logic signed [RingW-1:0] RoundHalf = 48'sh00008000000;

   localparam logic [0:0] CsrOutWidth = 1'b0;
   localparam logic [0:0] CsrHasAlpha = 1'b1;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_ACC   = 10'b0000000100,
      ST_CHK   = 10'b0000001000,
      ST_RD    = 10'b0000010000,
      ST_WR    = 10'b0000100000,
      ST_SHIFT = 10'b0001000000,
      ST_FIN   = 10'b0010000000,
      ST_DRD   = 10'b0100000000,
      ST_DOUT  = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic ready;
      logic clr_step;
      logic acc;
      logic rd;
      logic wr;
      logic shift;
      logic fin;
      logic drd;
      logic dout;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_valid;
      logic req_drain;
      logic k_last;
      logic close_go;
      logic out_busy;
   } status_type;

   function automatic logic signed [WinW-1:0] sat_win(input logic signed [WinW:0] v);
      logic signed [WinW-1:0] r;
      if (v[WinW] != v[WinW-1]) begin
         r = v[WinW] ? {1'b1, {(WinW-1){1'b0}}} : {1'b0, {(WinW-1){1'b1}}};
      end else begin
         r = v[WinW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [RingW-1:0] sat_ring(input logic signed [RingW:0] v);
      logic signed [RingW-1:0] r;
      if (v[RingW] != v[RingW-1]) begin
         r = v[RingW] ? {1'b1, {(RingW-1){1'b0}}} : {1'b0, {(RingW-1){1'b1}}};
      end else begin
         r = v[RingW-1:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] to_byte(input logic signed [RingW-1:0] s);
      logic [7:0]              r;
      logic signed [RingW-1:0] t;
      t = s + RoundHalf;
      if (s <= 0) begin
         r = 8'd0;
      end else if (s >= ByteSat) begin
         r = ByteMax;
      end else begin
         r = t[FracBits +: 8];
      end
      return r;
   endfunction

endpackage

>>> src/ssid_if.sv
// channel interfaces of the image downscaler
interface ssid_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [31:0]        pixel;
   logic signed [15:0] x_coeff_0;
   logic signed [15:0] x_coeff_1;
   logic signed [15:0] x_coeff_2;
   logic signed [15:0] x_coeff_3;
   logic [1:0]         closes_count;
   logic signed [15:0] y_coeff_0;
   logic signed [15:0] y_coeff_1;
   logic signed [15:0] y_coeff_2;
   logic signed [15:0] y_coeff_3;
   logic               row_end;
   modport source(output valid, action, pixel, x_coeff_0, x_coeff_1, x_coeff_2, x_coeff_3,
                  closes_count, y_coeff_0, y_coeff_1, y_coeff_2, y_coeff_3, row_end,
                  input ready);
   modport sink(input valid, action, pixel, x_coeff_0, x_coeff_1, x_coeff_2, x_coeff_3,
                closes_count, y_coeff_0, y_coeff_1, y_coeff_2, y_coeff_3, row_end,
                output ready);
endinterface

interface ssid_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;
   logic        row_done;
   modport source(output valid, out_pixel, row_done, input ready);
   modport sink(input valid, out_pixel, row_done, output ready);
endinterface

interface ssid_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [10:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> src/ssid_ram.sv
// generic single-port-write ram with registered read
module ssid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/ssid_ctrl.sv
// sequencing state machine of the image downscaler
module ssid_ctrl import ssid_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) state_in = status.req_drain ? ST_DRD : ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.k_last) state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = status.close_go ? ST_RD : ST_FIN;
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr   = 1'b1;
            state_in = status.k_last ? ST_SHIFT : ST_RD;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_CHK;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DRD: begin
            cmd.drd  = 1'b1;
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            if (!status.out_busy) begin
               cmd.dout = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> src/ssid_datapath.sv
// window accumulators, row ring memory, counters and output word register
module ssid_datapath import ssid_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   ssid_req_if.sink   req_chan,
   ssid_rsp_if.source rsp_chan,
   ssid_csr_if.sink   csr_chan
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int AW    = CW + 2;
   localparam int Depth = MAX_WIDTH * TapCount;
   localparam int EntW  = NumCh * RingW;
   localparam logic [WW-1:0] MaxW     = WW'(MAX_WIDTH);
   localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

   logic [10:0] out_width_ff;
   logic        has_alpha_ff;

   logic [31:0]             pixel_ff;
   logic signed [CoefW-1:0] xc_ff [TapCount];
   logic signed [CoefW-1:0] yc_ff [TapCount];
   logic                    row_end_ff;
   logic [1:0]              closes_ff;
   logic [1:0]              k_ff;
   logic [1:0]              tap_ff;
   logic [WW-1:0]           push_col_ff;
   logic [WW-1:0]           drain_col_ff;
   logic [AW-1:0]           clr_addr_ff;
   logic [AW-1:0]           addr_ff;

   logic signed [WinW-1:0]  win_ff  [NumCh][TapCount];
   logic signed [RingW-1:0] prod_ff [NumCh];

   logic                    rsp_valid_ff;
   logic [31:0]             out_pixel_ff;
   logic                    row_done_ff;

   logic                    accept;
   logic [WW-1:0]           width_eff;
   logic [WW-1:0]           drain_col;
   logic                    drain_last;
   logic [1:0]              row_k;
   logic signed [24:0]      acc_prod [NumCh];
   logic signed [WinW:0]    acc_wide [NumCh];
   logic signed [RingW:0]   ring_wide [NumCh];
   logic [EntW-1:0]         sum_entry;
   logic [7:0]              ch [NumCh];
   logic [7:0]              rgb_max;
   logic [7:0]              alpha;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [EntW-1:0]         ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [EntW-1:0]         ram_rd_data;

   assign accept         = cmd.ready & req_chan.valid;
   assign req_chan.ready = cmd.ready;
   assign csr_chan.ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff <= OutWidthRst;
         has_alpha_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CsrOutWidth: out_width_ff <= csr_chan.data;
            CsrHasAlpha: has_alpha_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (out_width_ff == 11'd0) begin
         width_eff = WW'(1);
      end else if (32'(out_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = MaxW;
      end else begin
         width_eff = WW'(out_width_ff);
      end
   end

   assign drain_col  = (drain_col_ff >= width_eff) ? width_eff - WW'(1) : drain_col_ff;
   assign drain_last = (drain_col == width_eff - WW'(1));
   assign row_k      = tap_ff + k_ff;

   // captured input word
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff   <= req_chan.pixel;
         xc_ff[0]   <= req_chan.x_coeff_0;
         xc_ff[1]   <= req_chan.x_coeff_1;
         xc_ff[2]   <= req_chan.x_coeff_2;
         xc_ff[3]   <= req_chan.x_coeff_3;
         yc_ff[0]   <= req_chan.y_coeff_0;
         yc_ff[1]   <= req_chan.y_coeff_1;
         yc_ff[2]   <= req_chan.y_coeff_2;
         yc_ff[3]   <= req_chan.y_coeff_3;
         row_end_ff <= req_chan.row_end;
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         closes_ff    <= '0;
         k_ff         <= '0;
         tap_ff       <= '0;
         push_col_ff  <= '0;
         drain_col_ff <= '0;
         clr_addr_ff  <= '0;
      end else begin
         if (accept) begin
            k_ff      <= '0;
            closes_ff <= (req_chan.closes_count == 2'd3) ? 2'd2 : req_chan.closes_count;
         end
         if (cmd.acc || cmd.wr) k_ff <= k_ff + 2'd1;
         if (cmd.shift) begin
            closes_ff   <= closes_ff - 2'd1;
            push_col_ff <= push_col_ff + WW'(1);
         end
         if (cmd.fin && row_end_ff) push_col_ff <= '0;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.dout) begin
            if (drain_last) begin
               drain_col_ff <= '0;
               tap_ff       <= tap_ff + 2'd1;
            end else begin
               drain_col_ff <= drain_col + WW'(1);
            end
         end
      end
   end

   // horizontal accumulate of all channels into the window tap selected by k
   always_comb begin
      for (int c = 0; c < NumCh; c++) begin
         acc_prod[c] = $signed({1'b0, pixel_ff[8*c +: 8]}) * xc_ff[k_ff];
         acc_wide[c] = win_ff[c][k_ff] + acc_prod[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NumCh; c++) begin
            for (int k = 0; k < TapCount; k++) win_ff[c][k] <= '0;
         end
      end else if (cmd.acc) begin
         for (int c = 0; c < NumCh; c++) win_ff[c][k_ff] <= sat_win(acc_wide[c]);
      end else if (cmd.shift) begin
         for (int c = 0; c < NumCh; c++) begin
            for (int k = 0; k < TapCount - 1; k++) win_ff[c][k] <= win_ff[c][k+1];
            win_ff[c][TapCount-1] <= '0;
         end
      end else if (cmd.fin && row_end_ff) begin
         for (int c = 0; c < NumCh; c++) begin
            for (int k = 0; k < TapCount; k++) win_ff[c][k] <= '0;
         end
      end
   end

   // vertical scatter read-modify-write
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         for (int c = 0; c < NumCh; c++) prod_ff[c] <= win_ff[c][0] * yc_ff[k_ff];
      end
      if (ram_rd_en) addr_ff <= ram_rd_addr;
   end

   always_comb begin
      for (int c = 0; c < NumCh; c++) begin
         ring_wide[c] = $signed(ram_rd_data[c*RingW +: RingW]) + prod_ff[c];
         sum_entry[c*RingW +: RingW] = sat_ring(ring_wide[c]);
         ch[c] = to_byte($signed(ram_rd_data[c*RingW +: RingW]));
      end
   end

   assign ram_rd_en   = cmd.rd | cmd.drd;
   assign ram_rd_addr = cmd.drd ? {drain_col[CW-1:0], tap_ff} : {push_col_ff[CW-1:0], row_k};
   assign ram_wr_en   = cmd.clr_step | cmd.wr | cmd.dout;
   assign ram_wr_addr = cmd.clr_step ? clr_addr_ff : addr_ff;
   assign ram_wr_data = cmd.wr ? sum_entry : '0;

   ssid_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // output word
   always_comb begin
      rgb_max = ch[0];
      if (ch[1] > rgb_max) rgb_max = ch[1];
      if (ch[2] > rgb_max) rgb_max = ch[2];
      if (!has_alpha_ff) begin
         alpha = ByteMax;
      end else begin
         alpha = (ch[3] > rgb_max) ? ch[3] : rgb_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.dout) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dout) begin
         out_pixel_ff <= {alpha, ch[2], ch[1], ch[0]};
         row_done_ff  <= drain_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_pixel = out_pixel_ff;
   assign rsp_chan.row_done  = row_done_ff;

   assign status.clr_last  = (clr_addr_ff == LastAddr);
   assign status.req_valid = req_chan.valid;
   assign status.req_drain = req_chan.action;
   assign status.k_last    = (k_ff == 2'd3);
   assign status.close_go  = (closes_ff != 2'd0) && (push_col_ff < width_eff);
   assign status.out_busy  = rsp_valid_ff & ~rsp_chan.ready;

   a_rsp_from_dout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.dout))
      else $error("output word appeared without a drain");
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> $past(cmd.rd))
      else $error("ring write without preceding read");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.dout |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("output word overwritten before taken");
endmodule

>>> src/streaming_separable_image_downscaler.sv
// top level of the streaming separable 4-tap image downscaler
// A push word accumulates one BGRA pixel into the horizontal window and
// scatters each closed column into the ring of row sums; a drain word returns
// one output pixel. After reset a clearing pass zeroes the ring memory, and no
// word is taken meanwhile. One word is processed at a time by a state machine
// around a single ring memory: a push accumulates the window, then for each
// closed column does four read-modify-writes of the ring, one window shift and
// one check; a drain reads the ring and then waits for the output register to be
// emptied. The output register lets the next word be taken while a result is
// still waiting.
module streaming_separable_image_downscaler import ssid_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input logic        clock,
   input logic        reset,
   ssid_req_if.sink   req_chan,
   ssid_rsp_if.source rsp_chan,
   ssid_csr_if.sink   csr_chan
);
   cmd_type    cmd;
   status_type status;

   ssid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   ssid_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );
endmodule
